// ===== src/wsm_pkg.sv =====
package wsm_pkg;

    localparam int MAX_QUEUES        = 8;
    localparam int PKTS_PER_QUEUE    = 64;
    localparam int SIZE_ALPHA_SHIFT  = 3;
    localparam int ROUND_ALPHA_SHIFT = 3;
    localparam int ROUND_FILTER      = 1;

    localparam int QIDX_W  = $clog2(MAX_QUEUES);
    localparam int SLOT_W  = $clog2(PKTS_PER_QUEUE);
    localparam int ADDR_W  = QIDX_W + SLOT_W;
    localparam int CNT_W   = SLOT_W + 1;
    localparam int RCNT_W  = $clog2(MAX_QUEUES + 1);
    localparam int ITER_W  = $clog2(MAX_QUEUES + 2);
    localparam int RING_W  = 3;

    localparam int BYTES_W = 14;
    localparam int QB_W    = 24;
    localparam int AVG_W   = 22;
    localparam int RT_W    = 40;
    localparam int TIME_W  = 32;
    localparam int DIV_W   = 64;
    localparam int DCNT_W  = $clog2(DIV_W);

    localparam logic [12:0]     NS_BYTE_MBPS = 13'd8000;
    localparam logic [RT_W-1:0] RT_MAX       = {RT_W{1'b1}};

    localparam logic [3:0]  RST_QUEUES = 4'd8;
    localparam logic [13:0] RST_MEAN   = 14'd1500;
    localparam logic [9:0]  RST_PTHR   = 10'd65;
    localparam logic [12:0] RST_BLIM   = 13'd1000;
    localparam logic [63:0] RST_WTAB   = 64'h0101010101010101;
    localparam logic [18:0] RST_LINK   = 19'd10000;

    typedef enum logic [2:0] {
        ST_ENQ    = 3'd0,
        ST_ENQ_CE = 3'd1,
        ST_DROP   = 3'd2,
        ST_DEQ    = 3'd3,
        ST_EMPTY  = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        MARK_QUEUE  = 2'd0,
        MARK_PORT   = 2'd1,
        MARK_MQ     = 2'd2,
        MARK_HYBRID = 2'd3
    } mark_mode_t;

    typedef enum logic [3:0] {
        REG_QUEUES = 4'd0,
        REG_MEAN   = 4'd1,
        REG_MODE   = 4'd2,
        REG_PTHR   = 4'd3,
        REG_BLIM   = 4'd4,
        REG_WTAB   = 4'd5,
        REG_QTAB   = 4'd6,
        REG_LINK   = 4'd7
    } cfg_reg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ENQ_START,
        S_ENQ_INIT,
        S_ENQ_CHECK,
        S_ENQ_MARK,
        S_ENQ_NUM,
        S_ENQ_DIV,
        S_ENQ_RPROD,
        S_ENQ_CMP,
        S_ENQ_UPD,
        S_DEQ_PASS,
        S_DEQ_SERVE,
        S_DEQ_TX,
        S_DONE
    } fsm_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

    function automatic logic [7:0] weight_of(input logic [63:0] tab,
                                             input logic [QIDX_W-1:0] q);
        logic [7:0] w;
        w = tab[{q, 3'b000} +: 8];
        return (w == 8'd0) ? 8'd1 : w;
    endfunction

    function automatic logic [7:0] qthresh_of(input logic [63:0] tab,
                                              input logic [QIDX_W-1:0] q);
        return tab[{q, 3'b000} +: 8];
    endfunction

    function automatic logic [RT_W-1:0] rt_ewma(input logic [RT_W-1:0] rt,
                                                input logic [RT_W:0] sample);
        logic [RT_W-1:0] s;
        s = (sample > {1'b0, RT_MAX}) ? RT_MAX : sample[RT_W-1:0];
        return rt - (rt >> ROUND_ALPHA_SHIFT) + (s >> ROUND_ALPHA_SHIFT);
    endfunction

endpackage

// ===== src/wsm_size_ram.sv =====
module wsm_size_ram
    import wsm_pkg::*;
(
    input  logic               clk,
    input  logic               we,
    input  logic [ADDR_W-1:0]  waddr,
    input  logic [BYTES_W-1:0] wdata,
    input  logic               re,
    input  logic [ADDR_W-1:0]  raddr,
    output logic [BYTES_W-1:0] rdata
);

    logic [BYTES_W-1:0] mem [MAX_QUEUES * PKTS_PER_QUEUE];
    logic [BYTES_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/wsm_div.sv =====
module wsm_div
    import wsm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0]  quo_reg, quo_next;
    logic [DIV_W-1:0]  rem_reg, rem_next;
    logic [DIV_W-1:0]  dsr_reg, dsr_next;
    logic [DIV_W:0]    trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        trial     = {rem_reg, quo_reg[DIV_W-1]};
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = req.dividend;
            rem_next  = '0;
            dsr_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = DIV_W'(trial - {1'b0, dsr_reg});
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DIV_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == {DCNT_W{1'b1}})
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== src/wrr_scheduler_ecn_marking.sv =====
// Weighted round robin scheduler over up to eight packet queues in one shared byte-limited
// buffer, with ECN marking per queue, per port, by MQ-ECN or hybrid mode. Items are handled one
// at a time. An enqueue steps through start, check, mark and update states; an MQ-ECN or hybrid
// decision adds numerator, divide, product and compare states, and the first enqueue after
// reset waits on the shared divider when the link rate is set; the divider retires one quotient
// bit per cycle over 64 steps. A dequeue skips each ring entry it cannot serve (at most nine)
// and waits on the divider when the served queue empties at the end of its credit and the link
// rate is set. Packet sizes sit in a 512-entry memory read in the cycle after its address; it
// needs no clearing pass. A new beat is taken while the last result still waits at the output.
module wrr_scheduler_ecn_marking
    import wsm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_addr,
    input  logic [63:0] cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // queue_sel, packet_bytes, ect, now_ns, zero pad
    input  logic        s_axis_tuser,   // mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // served_queue, served_bytes, zero pad
    output logic [2:0]  m_axis_tuser    // status
);

    logic [3:0]  nq_reg;
    logic [13:0] mean_reg;
    logic [1:0]  mmode_reg;
    logic [9:0]  pthr_reg;
    logic [12:0] blim_reg;
    logic [63:0] wtab_reg;
    logic [63:0] qtab_reg;
    logic [18:0] link_reg;

    fsm_t state_reg, state_next;
    logic started_reg, started_next;

    logic               in_mode_reg, in_mode_next;
    logic [7:0]         in_qid_reg, in_qid_next;
    logic [BYTES_W-1:0] in_size_reg, in_size_next;
    logic               in_ect_reg, in_ect_next;
    logic [TIME_W-1:0]  in_now_reg, in_now_next;

    logic [QIDX_W-1:0] q_reg, q_next;
    logic [26:0]       limit_reg, limit_next;
    logic [23:0]       port_reg, port_next;
    logic [21:0]       qth_reg, qth_next;
    logic [29:0]       wavg_reg, wavg_next;
    logic [58:0]       den_reg, den_next;
    logic [16:0]       ratio_reg, ratio_next;
    logic [40:0]       rprod_reg, rprod_next;
    logic              mark_reg, mark_next;
    logic [TIME_W-1:0] elapsed_reg, elapsed_next;
    logic [ITER_W-1:0] iter_reg, iter_next;

    logic [SLOT_W-1:0] fhead_reg [MAX_QUEUES];
    logic [SLOT_W-1:0] fhead_next [MAX_QUEUES];
    logic [CNT_W-1:0]  fcount_reg [MAX_QUEUES];
    logic [CNT_W-1:0]  fcount_next [MAX_QUEUES];
    logic [QB_W-1:0]   qbytes_reg [MAX_QUEUES];
    logic [QB_W-1:0]   qbytes_next [MAX_QUEUES];
    logic [AVG_W-1:0]  avg_reg [MAX_QUEUES];
    logic [AVG_W-1:0]  avg_next [MAX_QUEUES];
    logic [7:0]        credit_reg [MAX_QUEUES];
    logic [7:0]        credit_next [MAX_QUEUES];
    logic              active_reg [MAX_QUEUES];
    logic              active_next [MAX_QUEUES];
    logic              inround_reg [MAX_QUEUES];
    logic              inround_next [MAX_QUEUES];
    logic [TIME_W-1:0] rstart_reg [MAX_QUEUES];
    logic [TIME_W-1:0] rstart_next [MAX_QUEUES];
    logic [QIDX_W-1:0] ring_reg [1 << RING_W];
    logic [QIDX_W-1:0] ring_next [1 << RING_W];
    logic [RING_W-1:0] rhead_reg, rhead_next;
    logic [RCNT_W-1:0] rcount_reg, rcount_next;
    logic [RT_W-1:0]   rt_reg, rt_next;
    logic [QB_W-1:0]   total_reg, total_next;

    status_t            res_status_reg, res_status_next;
    logic [QIDX_W-1:0]  res_queue_reg, res_queue_next;
    logic [BYTES_W-1:0] res_bytes_reg, res_bytes_next;
    logic               out_valid_reg, out_valid_next;
    status_t            out_status_reg, out_status_next;
    logic [QIDX_W-1:0]  out_queue_reg, out_queue_next;
    logic [BYTES_W-1:0] out_bytes_reg, out_bytes_next;

    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [BYTES_W-1:0] mem_wdata;
    logic               mem_re;
    logic [ADDR_W-1:0]  mem_raddr;
    logic [BYTES_W-1:0] mem_rdata;
    div_req_t           div_req;
    div_rsp_t           div_rsp;

    logic [3:0]      n_used;
    logic [10:0]     tw;
    logic [QB_W-1:0] qb_sum;

    wsm_size_ram u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    wsm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nq_reg    <= RST_QUEUES;
            mean_reg  <= RST_MEAN;
            mmode_reg <= MARK_QUEUE;
            pthr_reg  <= RST_PTHR;
            blim_reg  <= RST_BLIM;
            wtab_reg  <= RST_WTAB;
            qtab_reg  <= '0;
            link_reg  <= RST_LINK;
        end
        else if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_addr))
                REG_QUEUES: nq_reg    <= cfg_data[3:0];
                REG_MEAN:   mean_reg  <= cfg_data[13:0];
                REG_MODE:   mmode_reg <= cfg_data[1:0];
                REG_PTHR:   pthr_reg  <= cfg_data[9:0];
                REG_BLIM:   blim_reg  <= cfg_data[12:0];
                REG_WTAB:   wtab_reg  <= cfg_data;
                REG_QTAB:   qtab_reg  <= cfg_data;
                REG_LINK:   link_reg  <= cfg_data[18:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        if (nq_reg == 4'd0)
        begin
            n_used = 4'd1;
        end
        else if (nq_reg > 4'(MAX_QUEUES))
        begin
            n_used = 4'(MAX_QUEUES);
        end
        else
        begin
            n_used = nq_reg;
        end
        tw = '0;
        for (int i = 0; i < MAX_QUEUES; i++)
        begin
            if (4'(i) < n_used)
            begin
                tw = tw + 11'(weight_of(wtab_reg, QIDX_W'(i)));
            end
        end
    end

    always_comb
    begin
        logic [QIDX_W-1:0]  dq;
        logic [TIME_W-1:0]  el;
        logic [7:0]         cr;
        logic [7:0]         ncr;
        logic [BYTES_W-1:0] sz;
        logic [23:0]        tw8k;
        logic [42:0]        num;
        logic [TIME_W:0]    tsum;
        logic [QB_W-1:0]    qb;

        state_next      = state_reg;
        started_next    = started_reg;
        in_mode_next    = in_mode_reg;
        in_qid_next     = in_qid_reg;
        in_size_next    = in_size_reg;
        in_ect_next     = in_ect_reg;
        in_now_next     = in_now_reg;
        q_next          = q_reg;
        limit_next      = limit_reg;
        port_next       = port_reg;
        qth_next        = qth_reg;
        wavg_next       = wavg_reg;
        den_next        = den_reg;
        ratio_next      = ratio_reg;
        rprod_next      = rprod_reg;
        mark_next       = mark_reg;
        elapsed_next    = elapsed_reg;
        iter_next       = iter_reg;
        fhead_next      = fhead_reg;
        fcount_next     = fcount_reg;
        qbytes_next     = qbytes_reg;
        avg_next        = avg_reg;
        credit_next     = credit_reg;
        active_next     = active_reg;
        inround_next    = inround_reg;
        rstart_next     = rstart_reg;
        ring_next       = ring_reg;
        rhead_next      = rhead_reg;
        rcount_next     = rcount_reg;
        rt_next         = rt_reg;
        total_next      = total_reg;
        res_status_next = res_status_reg;
        res_queue_next  = res_queue_reg;
        res_bytes_next  = res_bytes_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_queue_next  = out_queue_reg;
        out_bytes_next  = out_bytes_reg;
        mem_we          = 1'b0;
        mem_waddr       = {q_reg, SLOT_W'(fhead_reg[q_reg] + fcount_reg[q_reg][SLOT_W-1:0])};
        mem_wdata       = in_size_reg;
        mem_re          = 1'b0;
        dq              = ring_reg[rhead_reg];
        mem_raddr       = {dq, fhead_reg[dq]};
        div_req         = '0;
        el              = in_now_reg - rstart_reg[dq];
        cr              = inround_reg[dq] ? credit_reg[dq] : weight_of(wtab_reg, dq);
        sz              = mem_rdata;
        ncr             = credit_reg[q_reg] - 8'd1;
        tw8k            = 24'(tw) * 24'(NS_BYTE_MBPS);
        num             = 43'(wavg_reg) * 43'(NS_BYTE_MBPS);
        tsum            = {1'b0, elapsed_reg} + div_rsp.quotient[TIME_W:0];
        qb              = qbytes_reg[q_reg];
        s_axis_tready   = (state_reg == S_IDLE);

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    in_mode_next = s_axis_tuser;
                    in_qid_next  = s_axis_tdata[7:0];
                    in_size_next = s_axis_tdata[21:8];
                    in_ect_next  = s_axis_tdata[22];
                    in_now_next  = s_axis_tdata[54:23];
                    iter_next    = '0;
                    state_next   = s_axis_tuser ? S_DEQ_PASS : S_ENQ_START;
                end
            end
            S_ENQ_START:
            begin
                if (in_qid_reg >= {4'b0000, n_used})
                begin
                    q_next = QIDX_W'(n_used - 4'd1);
                end
                else
                begin
                    q_next = in_qid_reg[QIDX_W-1:0];
                end
                limit_next = 27'(blim_reg) * 27'(mean_reg);
                port_next  = 24'(pthr_reg) * 24'(mean_reg);
                state_next = S_ENQ_CHECK;
                if (!started_reg)
                begin
                    started_next = 1'b1;
                    for (int i = 0; i < MAX_QUEUES; i++)
                    begin
                        avg_next[i] = {mean_reg, 8'h00};
                    end
                    if (link_reg != '0)
                    begin
                        div_req.start    = 1'b1;
                        div_req.dividend = DIV_W'({tw8k, 8'h00});
                        div_req.divisor  = DIV_W'(link_reg);
                        state_next       = S_ENQ_INIT;
                    end
                    else
                    begin
                        rt_next = '0;
                    end
                end
            end
            S_ENQ_INIT:
            begin
                if (div_rsp.done)
                begin
                    rt_next    = div_rsp.quotient[RT_W-1:0];
                    state_next = S_ENQ_CHECK;
                end
            end
            S_ENQ_CHECK:
            begin
                qth_next       = 22'(qthresh_of(qtab_reg, q_reg)) * 22'(mean_reg);
                res_queue_next = q_reg;
                res_bytes_next = '0;
                if ((27'(total_reg) + 27'(in_size_reg)) > limit_reg
                    || fcount_reg[q_reg] >= CNT_W'(PKTS_PER_QUEUE))
                begin
                    res_status_next = ST_DROP;
                    state_next      = S_DONE;
                end
                else
                begin
                    mem_we              = 1'b1;
                    fcount_next[q_reg]  = fcount_reg[q_reg] + 1'b1;
                    qbytes_next[q_reg]  = qbytes_reg[q_reg] + QB_W'(in_size_reg);
                    total_next          = total_reg + QB_W'(in_size_reg);
                    state_next          = S_ENQ_MARK;
                end
            end
            S_ENQ_MARK:
            begin
                state_next = S_ENQ_UPD;
                case (mark_mode_t'(mmode_reg))
                    MARK_QUEUE: mark_next = qb > QB_W'(qth_reg);
                    MARK_PORT:  mark_next = total_reg > port_reg;
                    default:
                    begin
                        if (qb < QB_W'(qth_reg)
                            || (mmode_reg == MARK_HYBRID && total_reg < port_reg)
                            || rt_reg <= RT_W'(256) || link_reg == '0)
                        begin
                            mark_next = 1'b0;
                        end
                        else
                        begin
                            wavg_next  = 30'(weight_of(wtab_reg, q_reg)) * 30'(avg_reg[q_reg]);
                            den_next   = 59'(rt_reg) * 59'(link_reg);
                            state_next = S_ENQ_NUM;
                        end
                    end
                endcase
            end
            S_ENQ_NUM:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_W'({num, 16'h0000});
                div_req.divisor  = DIV_W'(den_reg);
                state_next       = S_ENQ_DIV;
            end
            S_ENQ_DIV:
            begin
                if (div_rsp.done)
                begin
                    if (div_rsp.quotient > DIV_W'(65536))
                    begin
                        ratio_next = 17'h10000;
                    end
                    else
                    begin
                        ratio_next = div_rsp.quotient[16:0];
                    end
                    state_next = S_ENQ_RPROD;
                end
            end
            S_ENQ_RPROD:
            begin
                rprod_next = 41'(ratio_reg) * 41'(port_reg);
                state_next = S_ENQ_CMP;
            end
            S_ENQ_CMP:
            begin
                mark_next  = {1'b0, qb, 16'h0000} > rprod_reg;
                state_next = S_ENQ_UPD;
            end
            S_ENQ_UPD:
            begin
                avg_next[q_reg] = avg_reg[q_reg] - (avg_reg[q_reg] >> SIZE_ALPHA_SHIFT)
                                  + ({in_size_reg, 8'h00} >> SIZE_ALPHA_SHIFT);
                res_status_next = (mark_reg && in_ect_reg) ? ST_ENQ_CE : ST_ENQ;
                if (!active_reg[q_reg])
                begin
                    credit_next[q_reg]  = '0;
                    active_next[q_reg]  = 1'b1;
                    inround_next[q_reg] = 1'b0;
                    rstart_next[q_reg]  = in_now_reg;
                    ring_next[RING_W'(rhead_reg + rcount_reg[RING_W-1:0])] = q_reg;
                    rcount_next = rcount_reg + 1'b1;
                end
                state_next = S_DONE;
            end
            S_DEQ_PASS:
            begin
                if (iter_reg > ITER_W'(MAX_QUEUES) || rcount_reg == '0)
                begin
                    res_status_next = ST_EMPTY;
                    res_queue_next  = '0;
                    res_bytes_next  = '0;
                    state_next      = S_DONE;
                end
                else
                begin
                    q_next       = dq;
                    elapsed_next = el;
                    if (cr != 8'd0 && fcount_reg[dq] != '0)
                    begin
                        credit_next[dq]  = cr;
                        inround_next[dq] = 1'b1;
                        mem_re           = 1'b1;
                        state_next       = S_DEQ_SERVE;
                    end
                    else
                    begin
                        rhead_next       = rhead_reg + 1'b1;
                        ring_next[RING_W'(rhead_reg + rcount_reg[RING_W-1:0])] = dq;
                        credit_next[dq]  = '0;
                        inround_next[dq] = 1'b0;
                        rt_next          = rt_ewma(rt_reg, {1'b0, el, 8'h00});
                        rstart_next[dq]  = in_now_reg;
                        iter_next        = iter_reg + 1'b1;
                    end
                end
            end
            S_DEQ_SERVE:
            begin
                fhead_next[q_reg]  = fhead_reg[q_reg] + 1'b1;
                fcount_next[q_reg] = fcount_reg[q_reg] - 1'b1;
                qbytes_next[q_reg] = qbytes_reg[q_reg] - QB_W'(sz);
                total_next         = total_reg - QB_W'(sz);
                credit_next[q_reg] = ncr;
                res_status_next    = ST_DEQ;
                res_queue_next     = q_reg;
                res_bytes_next     = sz;
                state_next         = S_DONE;
                if (fcount_reg[q_reg] == CNT_W'(1))
                begin
                    rhead_next          = rhead_reg + 1'b1;
                    rcount_next         = rcount_reg - 1'b1;
                    credit_next[q_reg]  = '0;
                    active_next[q_reg]  = 1'b0;
                    inround_next[q_reg] = 1'b0;
                    if (ncr == 8'd0 || ROUND_FILTER == 0)
                    begin
                        if (link_reg != '0)
                        begin
                            div_req.start    = 1'b1;
                            div_req.dividend = DIV_W'(27'(sz) * 27'(NS_BYTE_MBPS));
                            div_req.divisor  = DIV_W'(link_reg);
                            state_next       = S_DEQ_TX;
                        end
                        else
                        begin
                            rt_next = rt_ewma(rt_reg, {1'b0, elapsed_reg, 8'h00});
                        end
                    end
                end
            end
            S_DEQ_TX:
            begin
                if (div_rsp.done)
                begin
                    rt_next    = rt_ewma(rt_reg, {tsum, 8'h00});
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_queue_next  = res_queue_reg;
                    out_bytes_next  = res_bytes_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            started_reg   <= 1'b0;
            rhead_reg     <= '0;
            rcount_reg    <= '0;
            rt_reg        <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_QUEUES; i++)
            begin
                fhead_reg[i]   <= '0;
                fcount_reg[i]  <= '0;
                qbytes_reg[i]  <= '0;
                credit_reg[i]  <= '0;
                active_reg[i]  <= 1'b0;
                inround_reg[i] <= 1'b0;
                rstart_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            started_reg   <= started_next;
            rhead_reg     <= rhead_next;
            rcount_reg    <= rcount_next;
            rt_reg        <= rt_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
            fhead_reg     <= fhead_next;
            fcount_reg    <= fcount_next;
            qbytes_reg    <= qbytes_next;
            credit_reg    <= credit_next;
            active_reg    <= active_next;
            inround_reg   <= inround_next;
            rstart_reg    <= rstart_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_mode_reg    <= in_mode_next;
        in_qid_reg     <= in_qid_next;
        in_size_reg    <= in_size_next;
        in_ect_reg     <= in_ect_next;
        in_now_reg     <= in_now_next;
        q_reg          <= q_next;
        limit_reg      <= limit_next;
        port_reg       <= port_next;
        qth_reg        <= qth_next;
        wavg_reg       <= wavg_next;
        den_reg        <= den_next;
        ratio_reg      <= ratio_next;
        rprod_reg      <= rprod_next;
        mark_reg       <= mark_next;
        elapsed_reg    <= elapsed_next;
        iter_reg       <= iter_next;
        avg_reg        <= avg_next;
        ring_reg       <= ring_next;
        res_status_reg <= res_status_next;
        res_queue_reg  <= res_queue_next;
        res_bytes_reg  <= res_bytes_next;
        out_status_reg <= out_status_next;
        out_queue_reg  <= out_queue_next;
        out_bytes_reg  <= out_bytes_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {7'b0000000, out_bytes_reg, out_queue_reg};

    always_comb
    begin
        qb_sum = '0;
        for (int i = 0; i < MAX_QUEUES; i++)
        begin
            qb_sum = qb_sum + qbytes_reg[i];
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        rcount_reg <= RCNT_W'(MAX_QUEUES))
        else $error("Active ring holds more queues than exist.");

    assert property (@(posedge clk) disable iff (!rst_n)
        total_reg == qb_sum)
        else $error("Buffer total differs from the sum of queue byte counts.");

    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("Input beat taken while the previous one is still in work.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_status_reg != ST_DEQ |-> out_bytes_reg == '0)
        else $error("Nonzero size on a result that is not a dequeue.");

endmodule

// ===== tb/sv/wrr_scheduler_ecn_marking_tb.sv =====
module wrr_scheduler_ecn_marking_tb;
    import wsm_pkg::*;

    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;
    localparam int NUM_PHASES = 10;
    localparam int PHASE_ITEMS = 75;

    typedef struct {
        status_t    status;
        logic [2:0] queue;
        logic [13:0] bytes;
    } sched_result_t;

    typedef struct {
        logic        op;
        logic [7:0]  queue_sel;
        logic [13:0] bytes;
        logic        ect;
        logic [31:0] now;
        logic        typed;
        status_t     x_status;
        logic [2:0]  x_queue;
        logic [13:0] x_bytes;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [3:0]  cfg_addr;
    logic [63:0] cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata;   // queue_sel, packet_bytes, ect, now_ns, zero pad
    logic        s_axis_tuser;   // mode
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;   // served_queue, served_bytes, zero pad
    logic [2:0]  m_axis_tuser;   // status

    wrr_scheduler_ecn_marking dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Scheduler shadow state.
    logic [3:0]  sh_queues;
    logic [13:0] sh_mean;
    logic [1:0]  sh_mode;
    logic [9:0]  sh_pthr;
    logic [12:0] sh_blim;
    logic [63:0] sh_wtab;
    logic [63:0] sh_qtab;
    logic [18:0] sh_link;

    logic [13:0] sh_sizes [0:511];
    logic [5:0]  sh_head [0:7];
    logic [6:0]  sh_count [0:7];
    logic [31:0] sh_qbytes [0:7];
    logic [31:0] sh_avg [0:7];
    logic [7:0]  sh_credit [0:7];
    logic        sh_active [0:7];
    logic        sh_in_round [0:7];
    logic [31:0] sh_round_start [0:7];
    logic [2:0]  sh_ring [0:7];
    logic [2:0]  sh_ring_head;
    logic [3:0]  sh_ring_count;
    logic [63:0] sh_round_time;
    logic        sh_started;

    sched_result_t pending_results [$];
    int          error_count;
    int          tx_idle;
    int          rx_idle;
    logic [31:0] now_acc;
    stim_row_t   directed [0:15];
    logic [63:0] phase_cfg [0:NUM_PHASES-1][0:7];
    int          phase_enq_pct [0:NUM_PHASES-1];

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic [7:0] eff_weight(input logic [2:0] q);
        logic [7:0] w;
        w = sh_wtab[q*8 +: 8];
        return (w == 8'd0) ? 8'd1 : w;
    endfunction

    function automatic logic [63:0] link_tx_ns(input logic [63:0] bytes);
        return (sh_link == 0) ? 64'd0 : (bytes * 64'd8000) / sh_link;
    endfunction

    task automatic round_time_ewma(input logic [63:0] sample_ns);
        logic [63:0] s;
        s = sample_ns << 8;
        if (s > 64'hFF_FFFF_FFFF)
            s = 64'hFF_FFFF_FFFF;
        sh_round_time = sh_round_time - (sh_round_time >> ROUND_ALPHA_SHIFT)
                        + (s >> ROUND_ALPHA_SHIFT);
    endtask

    function automatic logic ce_wanted(input logic [2:0] q);
        logic [63:0] qb, tot, port, qth, num, den, ratio;
        qb = sh_qbytes[q];
        tot = 0;
        for (int i = 0; i < 8; i++)
            tot += sh_qbytes[i];
        port = 64'(sh_pthr) * sh_mean;
        qth = 64'(sh_qtab[q*8 +: 8]) * sh_mean;
        if (sh_mode == MARK_QUEUE)
            return qb > qth;
        if (sh_mode == MARK_PORT)
            return tot > port;
        if (qb < qth)
            return 1'b0;
        if (sh_mode == MARK_HYBRID && tot < port)
            return 1'b0;
        if (sh_round_time <= 256 || sh_link == 0)
            return 1'b0;
        num = 64'(eff_weight(q)) * sh_avg[q] * 64'd8000;
        den = sh_round_time * sh_link;
        ratio = (num << 16) / den;
        if (ratio > 64'd65536)
            ratio = 64'd65536;
        return (qb << 16) > ratio * port;
    endfunction

    task automatic predict_enqueue(input logic [7:0] qid, input logic [13:0] bytes,
                                   input logic ect, input logic [31:0] now,
                                   output sched_result_t r);
        int n;
        logic [63:0] tw, tot;
        logic [2:0] q;
        n = (sh_queues < 1) ? 1 : (sh_queues > 8) ? 8 : sh_queues;
        if (!sh_started)
        begin
            tw = 0;
            for (int i = 0; i < n; i++)
                tw += eff_weight(3'(i));
            sh_round_time = (sh_link == 0) ? 64'd0 : ((tw * 64'd8000) << 8) / sh_link;
            for (int i = 0; i < 8; i++)
                sh_avg[i] = 32'(sh_mean) << 8;
            sh_started = 1'b1;
        end
        q = (qid >= n) ? 3'(n - 1) : qid[2:0];
        r.queue = q;
        r.bytes = '0;
        tot = 0;
        for (int i = 0; i < 8; i++)
            tot += sh_qbytes[i];
        if (tot + bytes > 64'(sh_blim) * sh_mean || sh_count[q] >= PKTS_PER_QUEUE)
        begin
            r.status = ST_DROP;
            return;
        end
        sh_sizes[{q, 6'(sh_head[q] + sh_count[q])}] = bytes;
        sh_count[q]++;
        sh_qbytes[q] += bytes;
        r.status = (ce_wanted(q) && ect) ? ST_ENQ_CE : ST_ENQ;
        sh_avg[q] = sh_avg[q] - (sh_avg[q] >> SIZE_ALPHA_SHIFT)
                    + ((32'(bytes) << 8) >> SIZE_ALPHA_SHIFT);
        if (!sh_active[q])
        begin
            sh_credit[q] = 0;
            sh_active[q] = 1'b1;
            sh_in_round[q] = 1'b0;
            sh_round_start[q] = now;
            sh_ring[3'(sh_ring_head + sh_ring_count)] = q;
            sh_ring_count++;
        end
    endtask

    task automatic predict_dequeue(input logic [31:0] now, output sched_result_t r);
        logic [2:0] q;
        logic [31:0] elapsed;
        logic [13:0] size;
        r.status = ST_EMPTY;
        r.queue = '0;
        r.bytes = '0;
        for (int iter = 0; iter <= 8 && sh_ring_count > 0; iter++)
        begin
            q = sh_ring[sh_ring_head];
            elapsed = now - sh_round_start[q];
            if (!sh_in_round[q])
            begin
                sh_credit[q] = eff_weight(q);
                sh_in_round[q] = 1'b1;
            end
            if (sh_credit[q] > 0 && sh_count[q] > 0)
            begin
                size = sh_sizes[{q, sh_head[q]}];
                sh_head[q] = sh_head[q] + 6'd1;
                sh_count[q]--;
                sh_qbytes[q] -= size;
                sh_credit[q]--;
                if (sh_count[q] == 0)
                begin
                    if (sh_credit[q] == 0 || ROUND_FILTER == 0)
                        round_time_ewma(64'(elapsed) + link_tx_ns(size));
                    sh_ring_head++;
                    sh_ring_count--;
                    sh_credit[q] = 0;
                    sh_active[q] = 1'b0;
                    sh_in_round[q] = 1'b0;
                end
                r.status = ST_DEQ;
                r.queue = q;
                r.bytes = size;
                return;
            end
            sh_ring_head++;
            sh_ring_count--;
            sh_credit[q] = 0;
            sh_in_round[q] = 1'b0;
            round_time_ewma(64'(elapsed));
            sh_round_start[q] = now;
            sh_ring[3'(sh_ring_head + sh_ring_count)] = q;
            sh_ring_count++;
        end
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_QUEUES: sh_queues = val[3:0];
            REG_MEAN:   sh_mean = val[13:0];
            REG_MODE:   sh_mode = val[1:0];
            REG_PTHR:   sh_pthr = val[9:0];
            REG_BLIM:   sh_blim = val[12:0];
            REG_WTAB:   sh_wtab = val;
            REG_QTAB:   sh_qtab = val;
            REG_LINK:   sh_link = val[18:0];
            default:    ;
        endcase
    endtask

    task automatic send_item(input stim_row_t row);
        sched_result_t r;
        while ($urandom_range(99) < tx_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= row.op;
        s_axis_tdata <= {1'b0, row.now, row.ect, row.bytes, row.queue_sel};
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (row.op == OP_DEQ)
            predict_dequeue(row.now, r);
        else
            predict_enqueue(row.queue_sel, row.bytes, row.ect, row.now, r);
        if (row.typed)
        begin
            r.status = row.x_status;
            r.queue = row.x_queue;
            r.bytes = row.x_bytes;
        end
        pending_results.push_back(r);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle);
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                error_count++;
                $error("result beat with nothing expected");
            end
            else
            begin
                sched_result_t x;
                x = pending_results.pop_front();
                if (m_axis_tuser !== x.status)
                begin
                    error_count++;
                    $error("status expected %0d got %0d", x.status, m_axis_tuser);
                end
                if (m_axis_tdata[2:0] !== x.queue)
                begin
                    error_count++;
                    $error("served_queue expected %0d got %0d", x.queue, m_axis_tdata[2:0]);
                end
                if (m_axis_tdata[16:3] !== x.bytes)
                begin
                    error_count++;
                    $error("served_bytes expected %0d got %0d", x.bytes, m_axis_tdata[16:3]);
                end
            end
        end
    end

    initial
    begin
        #20000000;
        $display("wrr_scheduler_ecn_marking_tb: done, errors");
        $finish;
    end

    initial
    begin
        stim_row_t row;
        error_count = 0;
        tx_idle = 14;
        rx_idle = 81;
        now_acc = 0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_addr = '0;
        cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        m_axis_tready = 1'b0;
        sh_queues = RST_QUEUES;
        sh_mean = RST_MEAN;
        sh_mode = MARK_QUEUE;
        sh_pthr = RST_PTHR;
        sh_blim = RST_BLIM;
        sh_wtab = RST_WTAB;
        sh_qtab = '0;
        sh_link = RST_LINK;
        for (int i = 0; i < 8; i++)
        begin
            sh_head[i] = 0;
            sh_count[i] = 0;
            sh_qbytes[i] = 0;
            sh_avg[i] = 0;
            sh_credit[i] = 0;
            sh_active[i] = 0;
            sh_in_round[i] = 0;
            sh_round_start[i] = 0;
            sh_ring[i] = 0;
        end
        sh_ring_head = 0;
        sh_ring_count = 0;
        sh_round_time = 0;
        sh_started = 0;

        // Reset configuration: per-queue marking with zero thresholds marks any queue holding bytes.
        directed[0]  = '{OP_DEQ, 8'd0,   14'd0,     1'b0, 32'd0,          1, ST_EMPTY,  3'd0, 14'd0};
        directed[1]  = '{OP_ENQ, 8'd255, 14'd0,     1'b1, 32'd10,         1, ST_ENQ,    3'd7, 14'd0};
        directed[2]  = '{OP_ENQ, 8'd0,   14'd16383, 1'b1, 32'd20,         1, ST_ENQ_CE, 3'd0, 14'd0};
        directed[3]  = '{OP_ENQ, 8'd0,   14'd1,     1'b0, 32'd30,         1, ST_ENQ,    3'd0, 14'd0};
        directed[4]  = '{OP_ENQ, 8'd3,   14'd100,   1'b1, 32'd40,         1, ST_ENQ_CE, 3'd3, 14'd0};
        directed[5]  = '{OP_DEQ, 8'd0,   14'd0,     1'b0, 32'd50,         1, ST_DEQ,    3'd7, 14'd0};
        directed[6]  = '{OP_DEQ, 8'd0,   14'd0,     1'b0, 32'd60,         1, ST_DEQ,    3'd0, 14'd16383};
        directed[7]  = '{OP_DEQ, 8'hAA,  14'h2AAA,  1'b1, 32'hAAAA_AAAA,  0, ST_ENQ,    3'd0, 14'd0};
        directed[8]  = '{OP_ENQ, 8'd8,   14'h1555,  1'b1, 32'h5555_5555,  0, ST_ENQ,    3'd0, 14'd0};
        directed[9]  = '{OP_ENQ, 8'd128, 14'h2AAA,  1'b0, 32'hFFFF_FFF0,  0, ST_ENQ,    3'd0, 14'd0};
        directed[10] = '{OP_ENQ, 8'd7,   14'd1500,  1'b1, 32'hFFFF_FFFF,  0, ST_ENQ,    3'd0, 14'd0};
        directed[11] = '{OP_DEQ, 8'd0,   14'd0,     1'b0, 32'd5,          0, ST_ENQ,    3'd0, 14'd0};
        directed[12] = '{OP_DEQ, 8'd0,   14'd0,     1'b0, 32'd900,        0, ST_ENQ,    3'd0, 14'd0};
        directed[13] = '{OP_DEQ, 8'd0,   14'd0,     1'b0, 32'd1900,       0, ST_ENQ,    3'd0, 14'd0};
        directed[14] = '{OP_DEQ, 8'd0,   14'd0,     1'b0, 32'd2900,       0, ST_ENQ,    3'd0, 14'd0};
        directed[15] = '{OP_DEQ, 8'd0,   14'd0,     1'b0, 32'd3900,       0, ST_ENQ,    3'd0, 14'd0};

        for (int p = 0; p < NUM_PHASES; p++)
            for (int r = 0; r < 8; r++)
                phase_cfg[p][r] = {$urandom, $urandom};
        phase_cfg[0] = '{8, 1500, MARK_QUEUE, 65, 1000, 64'h0101010101010101, 0, 10000};
        phase_cfg[1] = '{1, 1, MARK_PORT, 0, 1, 0, 64'hFFFFFFFFFFFFFFFF, 1};
        phase_cfg[2] = '{3, 9216, MARK_MQ, 1023, 4096, phase_cfg[2][5], phase_cfg[2][6],
                         400000};
        phase_cfg[3] = '{15, 16383, MARK_HYBRID, 1023, 8191, phase_cfg[3][5],
                         phase_cfg[3][6] & 64'h0303030303030303, 524287};
        phase_cfg[4] = '{0, 200, MARK_MQ, 10, 50, phase_cfg[4][5], phase_cfg[4][6], 0};
        phase_cfg[5] = '{8, 1000, MARK_HYBRID, 20, 300, phase_cfg[5][5],
                         phase_cfg[5][6] & 64'h0F0F0F0F0F0F0F0F, 1000};
        phase_cfg[6] = '{5, 1500, MARK_PORT, 30, 100, phase_cfg[6][5], phase_cfg[6][6], 10000};
        phase_cfg[7] = '{8, 64, MARK_MQ, 5, 8191, phase_cfg[7][5] & 64'h0707070707070707,
                         phase_cfg[7][6] & 64'h0707070707070707, 100};
        phase_cfg[8] = '{2, 500, MARK_QUEUE, 3, 2000, phase_cfg[8][5], phase_cfg[8][6], 40000};
        phase_cfg[9] = '{8, 0, MARK_HYBRID, 1023, 4096, 64'hFFFFFFFFFFFFFFFF, 0, 400000};
        phase_enq_pct = '{55, 60, 70, 65, 60, 75, 55, 85, 50, 60};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        for (int i = 0; i < 16; i++)
            send_item(directed[i]);
        drain_results();
        now_acc = 4000;

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            tx_idle = (p < 4) ? 14 : (p < 8) ? 81 : 0;
            rx_idle = (p < 4) ? 81 : (p < 8) ? 14 : 0;
            for (int r = 0; r < 8; r++)
                write_reg(cfg_reg_t'(r), phase_cfg[p][r]);
            cfg_valid <= 1'b0;
            @(posedge clk);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                row.op = ($urandom_range(99) >= phase_enq_pct[p]) ? OP_DEQ : OP_ENQ;
                row.queue_sel = ($urandom_range(9) < 8) ? 8'($urandom_range(7))
                                                        : 8'($urandom_range(255));
                case ($urandom_range(9))
                    0:       row.bytes = 14'($urandom_range(3));
                    1, 2:    row.bytes = 14'($urandom_range(16383));
                    default: row.bytes = 14'($urandom_range(1600, 40));
                endcase
                row.ect = 1'($urandom_range(1));
                now_acc = ($urandom_range(19) == 0) ? $urandom
                                                    : now_acc + $urandom_range(3000);
                row.now = now_acc;
                row.typed = 1'b0;
                send_item(row);
            end
            drain_results();
        end

        repeat (200) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            error_count++;
            $error("%0d expected results never arrived", pending_results.size());
        end
        if (error_count == 0)
            $display("wrr_scheduler_ecn_marking_tb: done, clean");
        else
            $display("wrr_scheduler_ecn_marking_tb: done, errors");
        $finish;
    end

endmodule
